### design/wav_pcm16_mono_parser_unit_defines.svh
// Assertion macros for the WAV PCM16 mono parser unit.
// Expects signals named clock and reset in the module that uses them.
`ifndef WAV_PCM16_MONO_PARSER_UNIT_DEFINES_SVH
`define WAV_PCM16_MONO_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define WPM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wpm check failed");

// next-cycle implication, quiet during reset
`define WPM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wpm check failed");

`endif

### design/wpm_pkg.sv
// Shared types and status codes for the WAV PCM16 mono parser unit.
// No dependencies.
`timescale 1ns / 1ps

package wpm_pkg;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               sample_valid;
      logic               finished;
      logic [2:0]         status;
      logic [31:0]        rate_found;
   } rsp_item_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_TAG   = 3'd1;
   localparam logic [2:0] ST_TRUNCATED = 3'd2;
   localparam logic [2:0] ST_BAD_FMT   = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

endpackage

### design/wpm_in_stage.sv
// Input register of the parser: holds one byte item until the step logic takes it.
// Depends on wpm_pkg.
`timescale 1ns / 1ps

module wpm_in_stage
   import wpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic         advance,
   output logic         in_valid,
   output req_item_type in_item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         accept;

   // full and not draining this cycle
   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign in_valid = valid_ff;
   assign in_item  = item_ff;

endmodule

### design/wpm_step.sv
// Parser state and the per-byte step logic: header check, chunk walk, fmt capture,
// sample assembly. Depends on wpm_pkg and the unit's assertion macros.
`timescale 1ns / 1ps
`include "wav_pcm16_mono_parser_unit_defines.svh"

module wpm_step
   import wpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  req_item_type in_item,
   input  logic         advance,
   output logic         has_result,
   output rsp_item_type result
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_CHUNK  = 3'd1;
   localparam logic [2:0] PH_FMT    = 3'd2;
   localparam logic [2:0] PH_SKIP   = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;

   // tags as little-endian words, byte 0 in bits 7:0
   localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
   localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
   localparam logic [31:0] FMT_TAG  = 32'h2074_6D66;
   localparam logic [31:0] DATA_TAG = 32'h6174_6164;
   localparam logic [31:0] FMT_MIN  = 32'd16;

   function automatic logic [31:0] put32(logic [31:0] w, logic [1:0] pos, logic [7:0] b);
      logic [31:0] r;
      r = w;
      r[{pos, 3'b000} +: 8] = b;
      return r;
   endfunction

   function automatic logic [15:0] put16(logic [15:0] w, logic pos, logic [7:0] b);
      logic [15:0] r;
      r = w;
      r[{pos, 3'b000} +: 8] = b;
      return r;
   endfunction

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  header_count_ff, header_count_in;
   logic [31:0] chunk_tag_ff, chunk_tag_in;
   logic [31:0] chunk_length_ff, chunk_length_in;
   logic [32:0] bytes_left_ff, bytes_left_in;
   logic [4:0]  fmt_offset_ff, fmt_offset_in;
   logic [15:0] format_code_ff, format_code_in;
   logic [15:0] channel_count_ff, channel_count_in;
   logic [31:0] rate_store_ff, rate_store_in;
   logic [15:0] bit_depth_ff, bit_depth_in;
   logic [7:0]  low_half_ff, low_half_in;
   logic        odd_byte_ff, odd_byte_in;

   logic        smp_valid, fin, bad;
   logic [2:0]  st;
   logic [31:0] rate;
   logic [15:0] smp;
   logic [32:0] padded_len;
   logic [7:0]  b;

   assign b = in_item.file_byte;

   always_comb begin
      phase_in         = phase_ff;
      header_count_in  = header_count_ff;
      chunk_tag_in     = chunk_tag_ff;
      chunk_length_in  = chunk_length_ff;
      bytes_left_in    = bytes_left_ff;
      fmt_offset_in    = fmt_offset_ff;
      format_code_in   = format_code_ff;
      channel_count_in = channel_count_ff;
      rate_store_in    = rate_store_ff;
      bit_depth_in     = bit_depth_ff;
      low_half_in      = low_half_ff;
      odd_byte_in      = odd_byte_ff;
      smp_valid        = 1'b0;
      fin              = 1'b0;
      bad              = 1'b0;
      st               = ST_OK;
      rate             = 32'd0;
      smp              = 16'd0;
      padded_len       = 33'd0;

      case (phase_ff)
         PH_HEADER: begin
            if (header_count_ff < 4'd4) begin
               bad = (b != RIFF_TAG[{header_count_ff[1:0], 3'b000} +: 8]);
            end else if (header_count_ff >= 4'd8 && header_count_ff < 4'd12) begin
               bad = (b != WAVE_TAG[{header_count_ff[1:0], 3'b000} +: 8]);
            end
            if (bad) begin
               fin      = 1'b1;
               st       = ST_BAD_TAG;
               phase_in = PH_DONE;
            end else if (header_count_ff == 4'd11) begin
               header_count_in = 4'd0;
               phase_in        = PH_CHUNK;
            end else begin
               header_count_in = header_count_ff + 4'd1;
            end
         end
         PH_CHUNK: begin
            if (header_count_ff < 4'd4) begin
               chunk_tag_in = put32(chunk_tag_ff, header_count_ff[1:0], b);
            end else begin
               chunk_length_in = put32(chunk_length_ff, header_count_ff[1:0], b);
            end
            header_count_in = header_count_ff + 4'd1;
            padded_len = {1'b0, chunk_length_in} + {32'd0, chunk_length_in[0]};
            if (header_count_ff == 4'd7) begin
               header_count_in = 4'd0;
               if (chunk_tag_ff == FMT_TAG && chunk_length_in >= FMT_MIN) begin
                  fmt_offset_in = 5'd0;
                  bytes_left_in = padded_len;
                  phase_in      = PH_FMT;
               end else if (chunk_tag_ff == DATA_TAG) begin
                  if (format_code_ff != 16'd1 || channel_count_ff != 16'd1 ||
                      bit_depth_ff != 16'd16 || rate_store_ff == 32'd0 ||
                      chunk_length_in[0]) begin
                     fin      = 1'b1;
                     st       = ST_BAD_FMT;
                     phase_in = PH_DONE;
                  end else if (chunk_length_in == 32'd0) begin
                     fin      = 1'b1;
                     st       = ST_EMPTY;
                     phase_in = PH_DONE;
                  end else begin
                     bytes_left_in = {1'b0, chunk_length_in};
                     odd_byte_in   = 1'b0;
                     phase_in      = PH_DATA;
                  end
               end else begin
                  bytes_left_in = padded_len;
                  if (padded_len != 33'd0) begin
                     phase_in = PH_SKIP;
                  end
               end
            end
         end
         PH_FMT: begin
            if (fmt_offset_ff < 5'd2) begin
               format_code_in = put16(format_code_ff, fmt_offset_ff[0], b);
            end else if (fmt_offset_ff < 5'd4) begin
               channel_count_in = put16(channel_count_ff, fmt_offset_ff[0], b);
            end else if (fmt_offset_ff < 5'd8) begin
               rate_store_in = put32(rate_store_ff, fmt_offset_ff[1:0], b);
            end else if (fmt_offset_ff == 5'd14 || fmt_offset_ff == 5'd15) begin
               bit_depth_in = put16(bit_depth_ff, fmt_offset_ff[0], b);
            end
            if (fmt_offset_ff < 5'd16) begin
               fmt_offset_in = fmt_offset_ff + 5'd1;
            end
            bytes_left_in = bytes_left_ff - 33'd1;
            if (bytes_left_ff == 33'd1) begin
               phase_in = PH_CHUNK;
            end
         end
         PH_SKIP: begin
            bytes_left_in = bytes_left_ff - 33'd1;
            if (bytes_left_ff == 33'd1) begin
               phase_in = PH_CHUNK;
            end
         end
         PH_DATA: begin
            if (!odd_byte_ff) begin
               low_half_in = b;
               odd_byte_in = 1'b1;
            end else begin
               smp         = {b, low_half_ff};
               smp_valid   = 1'b1;
               odd_byte_in = 1'b0;
            end
            bytes_left_in = bytes_left_ff - 33'd1;
            if (bytes_left_ff == 33'd1) begin
               fin      = 1'b1;
               st       = ST_OK;
               rate     = rate_store_ff;
               phase_in = PH_DONE;
            end
         end
         default: begin
         end
      endcase

      // final byte of the file: report truncation if still open, then restart
      if (in_item.last_byte) begin
         if (phase_ff != PH_DONE && !fin) begin
            fin  = 1'b1;
            st   = ST_TRUNCATED;
            rate = 32'd0;
         end
         phase_in         = PH_HEADER;
         header_count_in  = 4'd0;
         chunk_tag_in     = 32'd0;
         chunk_length_in  = 32'd0;
         bytes_left_in    = 33'd0;
         fmt_offset_in    = 5'd0;
         format_code_in   = 16'd0;
         channel_count_in = 16'd0;
         rate_store_in    = 32'd0;
         bit_depth_in     = 16'd0;
         low_half_in      = 8'd0;
         odd_byte_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         header_count_ff  <= 4'd0;
         chunk_tag_ff     <= 32'd0;
         chunk_length_ff  <= 32'd0;
         bytes_left_ff    <= 33'd0;
         fmt_offset_ff    <= 5'd0;
         format_code_ff   <= 16'd0;
         channel_count_ff <= 16'd0;
         rate_store_ff    <= 32'd0;
         bit_depth_ff     <= 16'd0;
         low_half_ff      <= 8'd0;
         odd_byte_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         header_count_ff  <= header_count_in;
         chunk_tag_ff     <= chunk_tag_in;
         chunk_length_ff  <= chunk_length_in;
         bytes_left_ff    <= bytes_left_in;
         fmt_offset_ff    <= fmt_offset_in;
         format_code_ff   <= format_code_in;
         channel_count_ff <= channel_count_in;
         rate_store_ff    <= rate_store_in;
         bit_depth_ff     <= bit_depth_in;
         low_half_ff      <= low_half_in;
         odd_byte_ff      <= odd_byte_in;
      end
   end

   assign has_result          = smp_valid | fin;
   assign result.sample       = smp;
   assign result.sample_valid = smp_valid;
   assign result.finished     = fin;
   assign result.status       = fin ? st : ST_OK;
   assign result.rate_found   = (fin && st == ST_OK) ? rate : 32'd0;

   // a successful end always lands on the high byte of a sample
   `WPM_ASSERT_NOW(a_ok_has_sample,
      in_valid && result.finished && result.status == ST_OK, result.sample_valid)
   // counting phases never sit on an exhausted count
   `WPM_ASSERT_NOW(a_count_live,
      phase_ff == PH_FMT || phase_ff == PH_SKIP || phase_ff == PH_DATA,
      bytes_left_ff != 33'd0)
   // final byte restarts the parser
   `WPM_ASSERT_NEXT(a_last_restarts, advance && in_item.last_byte,
      phase_ff == PH_HEADER && header_count_ff == 4'd0 && rate_store_ff == 32'd0)

endmodule

### design/wpm_out_stage.sv
// Result register of the parser: holds one result item until the receiver takes it.
// Depends on wpm_pkg.
`timescale 1ns / 1ps

module wpm_out_stage
   import wpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

### design/wav_pcm16_mono_parser_unit.sv
// WAV PCM16 mono parser unit: the request side takes one file byte per cycle
// (req_item.file_byte, req_item.last_byte) under req_valid / req_stall.
// The response side gives zero or one item per byte under rsp_valid / rsp_stall:
// a little-endian 16-bit sample, an end-of-file status, or both.
// Status: ok, bad RIFF/WAVE tag, truncated, unsupported format, empty data.
// A truncated status voids every sample given earlier for that file.
// A byte accepted into the input register is parsed by the step logic into the
// result register, from which its item is shown on rsp_valid.
// Throughput: one byte per cycle unless stalled; every step is a few byte
// compares and one 33-bit count down between the input and result registers.
// Bytes that produce no item never wait on the response side.
// When the receiver stalls with an item pending, the input register fills and
// req_stall rises only when the next byte would produce another item.
// Reset (synchronous, active high) empties both registers and puts the parser
// at the start of a file; the byte flagged last_byte also restarts it.
// Depends on wpm_pkg, wpm_in_stage, wpm_step, wpm_out_stage.
`timescale 1ns / 1ps

module wav_pcm16_mono_parser_unit
   import wpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic         in_valid;
   req_item_type in_item;
   logic         advance;
   logic         has_result;
   rsp_item_type result;

   // move the held byte unless it makes an item and the result slot stays full
   assign advance = in_valid & (~has_result | ~rsp_valid | ~rsp_stall);

   wpm_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_item   (in_item)
   );

   wpm_step u_step (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid),
      .in_item    (in_item),
      .advance    (advance),
      .has_result (has_result),
      .result     (result)
   );

   wpm_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance & has_result),
      .load_item (result),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
